@@ rtl/core/hid_boot_report_event_decoder_macros.svh @@
// Assertion macros for the HID boot report event decoder.
// Used by the top level only; expects clk and rst in scope.
`ifndef HID_BOOT_REPORT_EVENT_DECODER_MACROS_SVH
`define HID_BOOT_REPORT_EVENT_DECODER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define HBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define HBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hbr_pkg.sv @@
// Shared types and constants for the HID boot report event decoder.
// No dependencies; used by all modules in rtl/core.
package hbr_pkg;

  // Key slot counts and report length minimums
  localparam int KEY_SLOTS     = 6;
  localparam int INPUT_SLOTS   = 6;
  localparam int NUM_EV        = 2 * KEY_SLOTS;
  localparam int MIN_KBD_LEN   = 2 + KEY_SLOTS;
  localparam int MIN_MOUSE_LEN = 3;

  localparam logic [7:0] LAST_RESERVED_CODE = 8'd3;
  localparam logic [7:0] SHIFT_MASK         = 8'h22;

  // Report kinds on the input tuser bit
  localparam logic RPT_KEYBOARD = 1'b0;
  localparam logic RPT_MOUSE    = 1'b1;

  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_MOUSE   = 2'd2
  } ev_kind_t;

  // One input report, unpacked
  typedef struct packed {
    logic                              req_type;
    logic [6:0]                        report_len;
    logic [7:0]                        modifier_bits;
    logic [INPUT_SLOTS-1:0][7:0]       key_slot;
    logic [2:0]                        mouse_buttons;
    logic signed [7:0]                 delta_x;
    logic signed [7:0]                 delta_y;
  } in_item_t;

  // Shared fields of all events raised by one report; event 2i is the
  // release of old slot i, event 2i+1 the press of new slot i
  typedef struct packed {
    logic                              is_mouse;
    logic [NUM_EV-1:0][7:0]            code;
    logic                              shift;
    logic [7:0]                        modifier;
    logic [31:0]                       pos_x;
    logic [31:0]                       pos_y;
    logic [2:0]                        buttons;
  } ev_info_t;

  // Bits of the event mask that carry presses
  function automatic logic [NUM_EV-1:0] ev_press_mask();
    logic [NUM_EV-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      m[2*i+1] = 1'b1;
    end
    return m;
  endfunction

endpackage

@@ rtl/core/hid_boot_report_event_decoder.sv @@
// Top level of the HID boot report event decoder.
// Depends on hbr_pkg, hbr_decode, hbr_emitter and the assertion macros.
`include "hid_boot_report_event_decoder_macros.svh"

// Takes USB HID boot-protocol keyboard and mouse reports and streams out
// key release/press events and mouse position updates. A report passes an
// input register, is decoded combinationally into a buffer of pending
// events, and the buffer feeds the output register at one event per cycle
// unless the output stalls. A mouse report or a keyboard report with at
// most one event frees the buffer as its event leaves, so such reports
// flow at one per cycle; a keyboard report with n events holds it until
// all n have left (up to 12 for six slots). The buffer's drain sets the
// rate. A result passes the input register, event buffer and output
// register. Short reports give no result and keep key and position state.
module hid_boot_report_event_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] report_len, [14:7] modifier_bits, [22:15]..[62:55] key_slot0..5,
  // [65:63] mouse_buttons, [73:66] delta_x, [81:74] delta_y, rest zero
  input  logic [87:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] key_code, [8] shift_held, [16:9] modifier_out, [48:17] pos_x,
  // [80:49] pos_y, [83:81] buttons_out, rest zero
  output logic [87:0] m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import hbr_pkg::*;

  in_item_t          in_item;
  in_item_t          s_item;
  logic              in_valid;
  logic              advance;
  logic              buf_free;
  logic              buf_busy;
  logic [NUM_EV-1:0] ev_mask;
  ev_info_t          ev_info;

  // Unpack the slave transaction
  always_comb begin
    s_item.req_type      = s_axis_tuser;
    s_item.report_len    = s_axis_tdata[6:0];
    s_item.modifier_bits = s_axis_tdata[14:7];
    s_item.key_slot[0]   = s_axis_tdata[22:15];
    s_item.key_slot[1]   = s_axis_tdata[30:23];
    s_item.key_slot[2]   = s_axis_tdata[38:31];
    s_item.key_slot[3]   = s_axis_tdata[46:39];
    s_item.key_slot[4]   = s_axis_tdata[54:47];
    s_item.key_slot[5]   = s_axis_tdata[62:55];
    s_item.mouse_buttons = s_axis_tdata[65:63];
    s_item.delta_x       = s_axis_tdata[73:66];
    s_item.delta_y       = s_axis_tdata[81:74];
  end

  assign advance       = in_valid && buf_free;
  assign s_axis_tready = !in_valid || buf_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_item;
    end
  end

  hbr_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .item    (in_item),
    .advance (advance),
    .ev_mask (ev_mask),
    .ev_info (ev_info)
  );

  hbr_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .ev_mask       (ev_mask),
    .ev_info       (ev_info),
    .buf_free      (buf_free),
    .buf_busy      (buf_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checks
  `HBR_ASSERT_NOW(a_mouse_last, m_axis_tvalid && (m_axis_tuser == EV_MOUSE),
                  m_axis_tlast, "mouse event not last of run")
  `HBR_ASSERT_NOW(a_key_no_pos, m_axis_tvalid && (m_axis_tuser != EV_MOUSE),
                  m_axis_tdata[83:17] == '0, "key event carries mouse fields")
  `HBR_ASSERT_NEXT(a_buf_drains, buf_busy, m_axis_tvalid, "pending events but no output")

endmodule

@@ rtl/core/hbr_decode.sv @@
// Report decoder: key slot diff against the previous report and mouse
// position accumulation. Holds the decoder state. Depends on hbr_pkg.
module hbr_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  hbr_pkg::in_item_t         item,
  input  logic                      advance,
  output logic [hbr_pkg::NUM_EV-1:0] ev_mask,
  output hbr_pkg::ev_info_t         ev_info
);
  import hbr_pkg::*;

  logic [KEY_SLOTS-1:0][7:0] previous_keys;
  logic [KEY_SLOTS-1:0][7:0] next_keys;
  logic [31:0]               position_x;
  logic [31:0]               position_y;
  logic [31:0]               position_x_next;
  logic [31:0]               position_y_next;
  logic                      kbd_ok;
  logic                      mouse_ok;
  logic                      shift;

  // Length checks and widened slot list
  always_comb begin
    kbd_ok   = (item.req_type == RPT_KEYBOARD) && (item.report_len >= 7'(MIN_KBD_LEN));
    mouse_ok = (item.req_type == RPT_MOUSE) && (item.report_len >= 7'(MIN_MOUSE_LEN));
    shift    = |(item.modifier_bits & SHIFT_MASK);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      next_keys[i] = (i < INPUT_SLOTS) ? item.key_slot[i] : 8'd0;
    end
    position_x_next = position_x + {{24{item.delta_x[7]}}, item.delta_x};
    position_y_next = position_y + {{24{item.delta_y[7]}}, item.delta_y};
  end

  // Slot matching: every old slot against every new slot in parallel
  always_comb begin
    logic old_kept;
    logic new_known;
    old_kept  = 1'b0;
    new_known = 1'b0;
    ev_mask   = '0;
    ev_info   = '0;
    if (kbd_ok) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        old_kept  = 1'b0;
        new_known = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
          if (previous_keys[i] == next_keys[j]) old_kept = 1'b1;
          if (next_keys[i] == previous_keys[j]) new_known = 1'b1;
        end
        ev_mask[2*i]   = (previous_keys[i] > LAST_RESERVED_CODE) && !old_kept;
        ev_mask[2*i+1] = (next_keys[i] > LAST_RESERVED_CODE) && !new_known;
        ev_info.code[2*i]   = previous_keys[i];
        ev_info.code[2*i+1] = next_keys[i];
      end
      ev_info.shift    = shift;
      ev_info.modifier = item.modifier_bits;
    end else if (mouse_ok) begin
      ev_mask[0]       = 1'b1;
      ev_info.is_mouse = 1'b1;
      ev_info.pos_x    = position_x_next;
      ev_info.pos_y    = position_y_next;
      ev_info.buttons  = item.mouse_buttons;
    end
  end

  // State update as the report leaves for the event buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
      position_x    <= '0;
      position_y    <= '0;
    end else if (advance) begin
      if (kbd_ok) begin
        previous_keys <= next_keys;
      end
      if (mouse_ok) begin
        position_x <= position_x_next;
        position_y <= position_y_next;
      end
    end
  end

endmodule

@@ rtl/core/hbr_emitter.sv @@
// Event buffer and output register: hands out the pending events of one
// report one per cycle unless stalled, lowest index first. Uses hbr_pkg.
module hbr_emitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [hbr_pkg::NUM_EV-1:0] ev_mask,
  input  hbr_pkg::ev_info_t          ev_info,
  output logic                       buf_free,
  output logic                       buf_busy,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [87:0]                m_axis_tdata,
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);
  import hbr_pkg::*;

  logic [NUM_EV-1:0] buf_mask;
  ev_info_t          buf_info;
  logic [NUM_EV-1:0] lowest;
  logic [NUM_EV-1:0] rest;
  logic [7:0]        code_sel;
  logic              is_press;
  logic              out_load;
  logic              pop;
  ev_kind_t          kind;

  // Pick the lowest pending event
  always_comb begin
    lowest   = buf_mask & (~buf_mask + NUM_EV'(1));
    rest     = buf_mask & ~lowest;
    code_sel = '0;
    for (int k = 0; k < NUM_EV; k++) begin
      code_sel = code_sel | (buf_info.code[k] & {8{lowest[k]}});
    end
    is_press = |(lowest & ev_press_mask());
    if (buf_info.is_mouse) begin
      kind = EV_MOUSE;
    end else if (is_press) begin
      kind = EV_PRESS;
    end else begin
      kind = EV_RELEASE;
    end
    out_load = !m_axis_tvalid || m_axis_tready;
    pop      = out_load && (|buf_mask);
    buf_busy = |buf_mask;
    buf_free = !buf_busy || (pop && !(|rest));
  end

  // Event buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_mask <= '0;
    end else if (load) begin
      buf_mask <= ev_mask;
    end else if (pop) begin
      buf_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_info <= ev_info;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= {4'b0, buf_info.buttons, buf_info.pos_y, buf_info.pos_x,
                       buf_info.modifier, buf_info.shift, code_sel};
      m_axis_tuser <= kind;
      m_axis_tlast <= !(|rest);
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the HID boot report event decoder.
// Depends on hbr_pkg and the hid_boot_report_event_decoder RTL; needs no other files.
`timescale 1ns / 1ps

module tb_top;
  import hbr_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 32;

  // One decoded event as it should leave the block
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  code;
    logic        shift;
    logic [7:0]  modifier;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [2:0]  buttons;
    logic        last;
  } hid_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow of the decoder state
  logic [7:0]  held_keys [KEY_SLOTS];
  logic [31:0] cursor_x;
  logic [31:0] cursor_y;

  hid_event_t  pending_events[$];
  hid_event_t  want_ev;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  hid_boot_report_event_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Expected events for one accepted report
  task automatic decode_report(input in_item_t rpt);
    hid_event_t evs [NUM_EV];
    logic [7:0] next_keys [KEY_SLOTS];
    logic       shift;
    logic       old_kept;
    logic       new_known;
    int         n;
    n = 0;
    if (rpt.req_type == RPT_KEYBOARD) begin
      if (rpt.report_len < MIN_KBD_LEN) return;
      shift = |(rpt.modifier_bits & SHIFT_MASK);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        next_keys[i] = (i < INPUT_SLOTS) ? rpt.key_slot[i] : 8'd0;
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        old_kept  = 1'b0;
        new_known = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
          if (held_keys[i] == next_keys[j]) old_kept = 1'b1;
          if (next_keys[i] == held_keys[j]) new_known = 1'b1;
        end
        // release of the old slot goes out before the press of the new one
        if (held_keys[i] > LAST_RESERVED_CODE && !old_kept) begin
          evs[n] = '{EV_RELEASE, held_keys[i], shift, rpt.modifier_bits, 32'd0, 32'd0,
                     3'd0, 1'b0};
          n++;
        end
        if (next_keys[i] > LAST_RESERVED_CODE && !new_known) begin
          evs[n] = '{EV_PRESS, next_keys[i], shift, rpt.modifier_bits, 32'd0, 32'd0,
                     3'd0, 1'b0};
          n++;
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = next_keys[i];
    end else begin
      if (rpt.report_len < MIN_MOUSE_LEN) return;
      cursor_x = cursor_x + {{24{rpt.delta_x[7]}}, rpt.delta_x};
      cursor_y = cursor_y + {{24{rpt.delta_y[7]}}, rpt.delta_y};
      evs[0] = '{EV_MOUSE, 8'd0, 1'b0, 8'd0, cursor_x, cursor_y, rpt.mouse_buttons, 1'b0};
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      evs[k].last = (k == n - 1);
      pending_events.push_back(evs[k]);
    end
  endtask

  // Drive one report and wait for its transaction
  task automatic send_report(input in_item_t rpt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rpt.req_type;
    s_axis_tdata  <= {6'd0, rpt.delta_y, rpt.delta_x, rpt.mouse_buttons, rpt.key_slot,
                      rpt.modifier_bits, rpt.report_len};
    do @(posedge clk); while (!s_axis_tready);
    decode_report(rpt);
  endtask

  function automatic in_item_t kbd(input int len, input logic [7:0] mods,
                                   input logic [7:0] k0, input logic [7:0] k1,
                                   input logic [7:0] k2, input logic [7:0] k3,
                                   input logic [7:0] k4, input logic [7:0] k5);
    in_item_t r;
    r.req_type      = RPT_KEYBOARD;
    r.report_len    = 7'(len);
    r.modifier_bits = mods;
    r.key_slot[0]   = k0;
    r.key_slot[1]   = k1;
    r.key_slot[2]   = k2;
    r.key_slot[3]   = k3;
    r.key_slot[4]   = k4;
    r.key_slot[5]   = k5;
    // mouse fields are don't-care here
    r.mouse_buttons = 3'($urandom);
    r.delta_x       = 8'($urandom);
    r.delta_y       = 8'($urandom);
    return r;
  endfunction

  function automatic in_item_t mouse(input int len, input logic [2:0] btn,
                                     input logic signed [7:0] dx,
                                     input logic signed [7:0] dy);
    in_item_t r;
    r.req_type      = RPT_MOUSE;
    r.report_len    = 7'(len);
    r.modifier_bits = 8'($urandom);
    for (int i = 0; i < INPUT_SLOTS; i++) r.key_slot[i] = 8'($urandom);
    r.mouse_buttons = btn;
    r.delta_x       = dx;
    r.delta_y       = dy;
    return r;
  endfunction

  // Keyboard report that often reuses held keys so releases and presses mix
  function automatic in_item_t rand_keyboard(input bit full_len);
    in_item_t r;
    int       pick;
    r = kbd(full_len ? (($urandom_range(3) != 0) ? MIN_KBD_LEN : $urandom_range(MIN_KBD_LEN, 64))
                     : $urandom_range(0, MIN_KBD_LEN - 1),
            8'($urandom), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)      r.key_slot[i] = held_keys[$urandom_range(KEY_SLOTS - 1)];
      else if (pick < 50) r.key_slot[i] = 8'd0;
      else if (pick < 60) r.key_slot[i] = 8'($urandom_range(1, LAST_RESERVED_CODE));
      else if (pick < 75) r.key_slot[i] = 8'($urandom_range(4, 15));
      else                r.key_slot[i] = 8'($urandom);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Output monitor: every transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: unexpected event, expected none actual kind %h data %h", $time,
                   m_axis_tuser, m_axis_tdata);
      end else begin
        want_ev = pending_events.pop_front();
        compare_field("event_kind", 32'(want_ev.kind), 32'(m_axis_tuser));
        compare_field("key_code", 32'(want_ev.code), 32'(m_axis_tdata[7:0]));
        compare_field("shift_held", 32'(want_ev.shift), 32'(m_axis_tdata[8]));
        compare_field("modifier_out", 32'(want_ev.modifier), 32'(m_axis_tdata[16:9]));
        compare_field("pos_x", want_ev.pos_x, m_axis_tdata[48:17]);
        compare_field("pos_y", want_ev.pos_y, m_axis_tdata[80:49]);
        compare_field("buttons_out", 32'(want_ev.buttons), 32'(m_axis_tdata[83:81]));
        compare_field("tdata_pad", 32'd0, 32'(m_axis_tdata[87:84]));
        compare_field("last_of_run", 32'(want_ev.last), 32'(m_axis_tlast));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Presses, releases, reserved codes, duplicates and slot moves
  task automatic test_keyboard_directed();
    send_report(kbd(MIN_KBD_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(kbd(MIN_KBD_LEN, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    // full rollover: twelve events, the most one report can give
    send_report(kbd(MIN_KBD_LEN, 8'h20, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA));
    send_report(kbd(MIN_KBD_LEN, 8'hFF, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF));
    send_report(kbd(MIN_KBD_LEN, 8'hDD, 8'h01, 8'h02, 8'h03, 8'h00, 8'hFF, 8'h04));
    send_report(kbd(64, 8'h00, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00));
    send_report(kbd(MIN_KBD_LEN + 1, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10));
    send_report(kbd(MIN_KBD_LEN, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Short reports must leave key and position state alone
  task automatic test_short_reports();
    send_report(kbd(MIN_KBD_LEN - 1, 8'hAA, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(kbd(0, 8'h55, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0));
    send_report(kbd(MIN_KBD_LEN, 8'h02, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mouse(MIN_MOUSE_LEN - 1, 3'd7, 8'sd100, -8'sd100));
    send_report(mouse(0, 3'd5, -8'sd1, 8'sd1));
    send_report(mouse(MIN_MOUSE_LEN, 3'd1, 8'sd1, 8'sd1));
  endtask

  // Displacement extremes in both directions
  task automatic test_mouse_directed();
    send_report(mouse(MIN_MOUSE_LEN, 3'd7, 8'sd127, -8'sd128));
    send_report(mouse(64, 3'd0, -8'sd128, 8'sd127));
    send_report(mouse(5, 3'd5, -8'sd1, 8'sd1));
    send_report(mouse(MIN_MOUSE_LEN, 3'd2, 8'sd0, 8'sd0));
  endtask

  // Mixed traffic; short reports are noise and are not counted
  task automatic test_random_traffic(input int num_reports);
    int counted;
    int pick;
    counted = 0;
    while (counted < num_reports) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_report(rand_keyboard(1'b1));
        counted++;
      end else if (pick < 85) begin
        send_report(mouse($urandom_range(MIN_MOUSE_LEN, 64), 3'($urandom),
                          8'($urandom), 8'($urandom)));
        counted++;
      end else if (pick < 93) begin
        send_report(rand_keyboard(1'b0));
      end else begin
        send_report(mouse($urandom_range(0, MIN_MOUSE_LEN - 1), 3'($urandom),
                          8'($urandom), 8'($urandom)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = 8'd0;
    cursor_x = 32'd0;
    cursor_y = 32'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 6;
    sink_stall_pct = 51;
    test_keyboard_directed();
    test_short_reports();
    test_mouse_directed();
    test_random_traffic(55);

    src_idle_pct   = 51;
    sink_stall_pct = 6;
    test_random_traffic(55);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_traffic(55);

    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hbr_pkg.sv
rtl/core/hbr_decode.sv
rtl/core/hbr_emitter.sv
rtl/core/hid_boot_report_event_decoder.sv
tb/tb_top.sv
